@@ hdl/asd_pkg.sv @@
package asd_pkg;

  // field and state widths
  localparam int PRICE_W     = 48;
  localparam int QTY_W       = 32;
  localparam int STEP_W      = 32;
  localparam int ACC_W       = 64;
  localparam int COUNT_W     = 32;
  localparam int LIMIT_W     = 47;
  localparam int THRESH_W    = 16;
  localparam int BPS_W       = 47;
  localparam int QUOTE_W     = 47;
  localparam int CFG_DATA_W  = 47;
  localparam int CFG_INDEX_W = 1;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // fill product split: low half unsigned, high half signed
  localparam int HALF_W      = 24;
  localparam int LO_PROD_W   = HALF_W + QTY_W;
  localparam int HI_PROD_W   = ACC_W - HALF_W;

  // spread division
  localparam int BPS_SCALE   = 10000;
  localparam int SCALE_W     = 14;
  localparam int SPREAD_W    = QUOTE_W;
  localparam int DIVIDEND_W  = SPREAD_W + SCALE_W;
  localparam int QUO_W       = 15;
  localparam int QCNT_W      = 4;
  localparam int BPS_MAX     = 20000;

  localparam logic [1:0] ACT_FILL  = 2'd0;
  localparam logic [1:0] ACT_QUOTE = 2'd1;
  localparam logic [1:0] ACT_EOS   = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_POSITION_LIMIT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD_BPS  = 1'd1;

  localparam logic [LIMIT_W-1:0]  POSITION_LIMIT_RST = 47'd1000000;
  localparam logic [THRESH_W-1:0] THRESHOLD_RST      = 16'd5;

  typedef enum logic [1:0] {
    CMD_FILL,
    CMD_QUOTE,
    CMD_EOS
  } cmd_kind_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FILL_ACC,
    BK_EOS_PREP,
    BK_EOS_DIV,
    BK_EOS_DONE
  } back_state_t;

  typedef struct packed {
    logic [1:0]                action;
    logic signed [PRICE_W-1:0] fill_price;
    logic [QTY_W-1:0]          fill_size;
    logic signed [PRICE_W-1:0] quote_bid;
    logic signed [PRICE_W-1:0] quote_ask;
    logic [STEP_W-1:0]         step_number;
  } in_item_t;

  typedef struct packed {
    logic                    signal_valid;
    logic [BPS_W-1:0]        spread_bps;
    logic [STEP_W-1:0]       signal_step;
    logic                    halt_request;
    logic signed [ACC_W-1:0] position_out;
    logic signed [ACC_W-1:0] pnl_out;
    logic [COUNT_W-1:0]      fills_out;
    logic [COUNT_W-1:0]      signals_out;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic signed [PRICE_W-1:0] price;
    logic [QTY_W-1:0]          qty;
    logic [QUOTE_W-1:0]        bid;
    logic                      bid_ok;
    logic [QUOTE_W-1:0]        ask;
    logic                      ask_ok;
    logic [STEP_W-1:0]         step;
  } cmd_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [SPREAD_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ hdl/asd_front.sv @@
module asd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  asd_pkg::in_item_t in_data,
  output logic              push_valid,
  input  logic              push_ready,
  output asd_pkg::cmd_t     push_cmd
);

  logic          fr_valid_r;
  asd_pkg::cmd_t cmd_r;
  asd_pkg::cmd_t cmd_nxt;
  logic          keep;
  logic          take;

  assign in_ready   = !fr_valid_r || push_ready;
  assign take       = in_valid && in_ready;
  assign push_valid = fr_valid_r;
  assign push_cmd   = cmd_r;

  // classify the message; unused action code is dropped here
  always_comb begin
    cmd_nxt.price  = in_data.fill_price;
    cmd_nxt.qty    = in_data.fill_size;
    cmd_nxt.bid    = in_data.quote_bid[asd_pkg::QUOTE_W-1:0];
    cmd_nxt.bid_ok = !in_data.quote_bid[asd_pkg::PRICE_W-1] && (in_data.quote_bid != '0);
    cmd_nxt.ask    = in_data.quote_ask[asd_pkg::QUOTE_W-1:0];
    cmd_nxt.ask_ok = !in_data.quote_ask[asd_pkg::PRICE_W-1] && (in_data.quote_ask != '0);
    cmd_nxt.step   = in_data.step_number;
    keep           = 1'b1;
    unique case (in_data.action)
      asd_pkg::ACT_FILL:  cmd_nxt.kind = asd_pkg::CMD_FILL;
      asd_pkg::ACT_QUOTE: cmd_nxt.kind = asd_pkg::CMD_QUOTE;
      asd_pkg::ACT_EOS:   cmd_nxt.kind = asd_pkg::CMD_EOS;
      default: begin
        cmd_nxt.kind = asd_pkg::CMD_EOS;
        keep         = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (take) begin
      fr_valid_r <= keep;
    end else if (push_ready) begin
      fr_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

@@ hdl/asd_queue.sv @@
module asd_queue #(
  parameter int DEPTH = asd_pkg::QUEUE_DEPTH  // power of two, at least 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  asd_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output asd_pkg::cmd_t pop_cmd
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  asd_pkg::cmd_t    slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push;
  logic             pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_ready && pop_valid;
  assign pop_cmd    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ hdl/asd_div.sv @@
module asd_div (
  input  logic              clk,
  input  logic              rst_n,
  input  asd_pkg::div_req_t req,
  output asd_pkg::div_rsp_t rsp
);

  logic                           busy_r;
  logic                           done_r;
  logic [asd_pkg::QCNT_W-1:0]     cnt_r;
  logic [asd_pkg::DIVIDEND_W-1:0] rem_r;
  logic [asd_pkg::DIVIDEND_W-1:0] dsr_r;
  logic [asd_pkg::QUO_W-1:0]      quo_r;
  logic                           fits;
  logic [asd_pkg::DIVIDEND_W-1:0] rem_diff;

  // restoring division, one quotient bit per cycle, msb first
  assign fits     = (rem_r >= dsr_r);
  assign rem_diff = rem_r - dsr_r;

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= asd_pkg::QCNT_W'(asd_pkg::QUO_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r - asd_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.dividend;
      dsr_r <= asd_pkg::DIVIDEND_W'(req.divisor) << (asd_pkg::QUO_W - 1);
      quo_r <= '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_diff;
      end
      quo_r <= {quo_r[asd_pkg::QUO_W-2:0], fits};
      dsr_r <= dsr_r >> 1;
    end
  end

endmodule

@@ hdl/asd_back.sv @@
module asd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  input  asd_pkg::cmd_t                 cmd,
  output logic                          cmd_pop,
  input  logic [asd_pkg::LIMIT_W-1:0]   position_limit,
  input  logic [asd_pkg::THRESH_W-1:0]  threshold_bps,
  output asd_pkg::div_req_t             div_req,
  input  asd_pkg::div_rsp_t             div_rsp,
  output logic                          out_valid,
  input  logic                          out_ready,
  output asd_pkg::out_item_t            out_data
);

  asd_pkg::back_state_t state_r;
  asd_pkg::back_state_t state_nxt;

  // model state
  logic [asd_pkg::ACC_W-1:0]     pos_r;
  logic [asd_pkg::ACC_W-1:0]     pnl_r;
  logic [asd_pkg::COUNT_W-1:0]   fills_r;
  logic [asd_pkg::COUNT_W-1:0]   sigs_r;
  logic [asd_pkg::QUOTE_W-1:0]   bid_r;
  logic [asd_pkg::QUOTE_W-1:0]   ask_r;
  logic                          seen_r;

  // working registers
  logic [asd_pkg::LO_PROD_W-1:0] p_lo_r;
  logic [asd_pkg::HI_PROD_W-1:0] p_hi_r;
  logic [asd_pkg::STEP_W-1:0]    step_r;
  logic                          quote_ok_r;
  logic [asd_pkg::SPREAD_W-1:0]  spread_r;
  logic [asd_pkg::SPREAD_W-1:0]  mid_r;
  logic [asd_pkg::ACC_W-1:0]     mag_r;
  logic                          over_r;
  logic [asd_pkg::QUO_W-1:0]     bps_r;

  logic                          out_valid_r;
  asd_pkg::out_item_t            out_data_r;

  logic                          out_free;
  logic                          out_load;
  logic                          pop_fill;
  logic                          pop_quote;
  logic                          pop_eos;
  logic                          sig;
  logic [asd_pkg::HI_PROD_W-1:0] hi_ext;
  logic [asd_pkg::ACC_W-1:0]     fill_prod;
  asd_pkg::out_item_t            out_nxt;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      asd_pkg::BK_IDLE: begin
        if (cmd_valid && cmd.kind == asd_pkg::CMD_FILL) begin
          state_nxt = asd_pkg::BK_FILL_ACC;
        end else if (cmd_valid && cmd.kind == asd_pkg::CMD_EOS) begin
          state_nxt = asd_pkg::BK_EOS_PREP;
        end
      end
      asd_pkg::BK_FILL_ACC: state_nxt = asd_pkg::BK_IDLE;
      asd_pkg::BK_EOS_PREP: begin
        state_nxt = quote_ok_r ? asd_pkg::BK_EOS_DIV : asd_pkg::BK_EOS_DONE;
      end
      asd_pkg::BK_EOS_DIV: begin
        if (div_rsp.done) begin
          state_nxt = asd_pkg::BK_EOS_DONE;
        end
      end
      asd_pkg::BK_EOS_DONE: begin
        if (out_free) begin
          state_nxt = asd_pkg::BK_IDLE;
        end
      end
      default: state_nxt = asd_pkg::BK_IDLE;
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    cmd_pop   = (state_r == asd_pkg::BK_IDLE) && cmd_valid;
    pop_fill  = cmd_pop && (cmd.kind == asd_pkg::CMD_FILL);
    pop_quote = cmd_pop && (cmd.kind == asd_pkg::CMD_QUOTE);
    pop_eos   = cmd_pop && (cmd.kind == asd_pkg::CMD_EOS);
    out_load  = (state_r == asd_pkg::BK_EOS_DONE) && out_free;

    div_req.start    = (state_r == asd_pkg::BK_EOS_PREP) && quote_ok_r;
    div_req.dividend = asd_pkg::DIVIDEND_W'(spread_r) *
                       asd_pkg::DIVIDEND_W'(asd_pkg::BPS_SCALE);
    div_req.divisor  = mid_r;

    // price * qty mod 2^64 as signed high half and unsigned low half
    hi_ext    = asd_pkg::HI_PROD_W'(signed'(cmd.price[asd_pkg::PRICE_W-1:asd_pkg::HALF_W]));
    fill_prod = {p_hi_r, {asd_pkg::HALF_W{1'b0}}} + asd_pkg::ACC_W'(p_lo_r);

    sig = quote_ok_r && (asd_pkg::THRESH_W'(bps_r) >= threshold_bps);

    out_nxt.signal_valid = sig;
    out_nxt.spread_bps   = sig ? asd_pkg::BPS_W'(bps_r) : '0;
    out_nxt.signal_step  = sig ? step_r : '0;
    out_nxt.halt_request = over_r || (!seen_r && !sig);
    out_nxt.position_out = pos_r;
    out_nxt.pnl_out      = pnl_r;
    out_nxt.fills_out    = fills_r;
    out_nxt.signals_out  = sigs_r + asd_pkg::COUNT_W'(sig);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= asd_pkg::BK_IDLE;
      pos_r       <= '0;
      pnl_r       <= '0;
      fills_r     <= '0;
      sigs_r      <= '0;
      bid_r       <= '0;
      ask_r       <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop_fill) begin
        pos_r   <= pos_r + asd_pkg::ACC_W'(cmd.qty);
        fills_r <= fills_r + asd_pkg::COUNT_W'(1);
        seen_r  <= 1'b1;
      end
      if (pop_quote) begin
        if (cmd.bid_ok) begin
          bid_r <= cmd.bid;
        end
        if (cmd.ask_ok) begin
          ask_r <= cmd.ask;
        end
        seen_r <= 1'b1;
      end
      if (state_r == asd_pkg::BK_FILL_ACC) begin
        pnl_r <= pnl_r - fill_prod;
      end
      if (out_load) begin
        sigs_r <= out_nxt.signals_out;
        seen_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_fill) begin
      p_lo_r <= asd_pkg::LO_PROD_W'(cmd.price[asd_pkg::HALF_W-1:0]) *
                asd_pkg::LO_PROD_W'(cmd.qty);
      p_hi_r <= hi_ext * asd_pkg::HI_PROD_W'(cmd.qty);
    end
    if (pop_eos) begin
      step_r     <= cmd.step;
      quote_ok_r <= (bid_r != '0) && (ask_r != '0) && (bid_r > ask_r);
      spread_r   <= bid_r - ask_r;
      mid_r      <= asd_pkg::SPREAD_W'(({1'b0, bid_r} + {1'b0, ask_r}) >> 1);
      mag_r      <= pos_r[asd_pkg::ACC_W-1] ? (~pos_r + asd_pkg::ACC_W'(1)) : pos_r;
      bps_r      <= '0;
    end
    if (state_r == asd_pkg::BK_EOS_PREP) begin
      over_r <= (mag_r > asd_pkg::ACC_W'(position_limit));
    end
    if ((state_r == asd_pkg::BK_EOS_DIV) && div_rsp.done) begin
      bps_r <= div_rsp.quotient;
    end
    if (out_load) begin
      out_data_r <= out_nxt;
    end
  end

  // divider only ever sees a crossed book with a nonzero mid, and only when free
  a_div_start_ok: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> (quote_ok_r && (mid_r != '0) && !div_rsp.busy))
    else $error("divider started without a crossed quote");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == asd_pkg::BK_EOS_DIV))
    else $error("divider finished outside the divide state");

  a_bps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (div_rsp.quotient < asd_pkg::QUO_W'(asd_pkg::BPS_MAX)))
    else $error("spread quotient out of range");

  a_seen_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> !seen_r)
    else $error("message flag not cleared by end of step");

endmodule

@@ hdl/arbitrage_spread_detector.sv @@
// market-maker spread detector. fills, price updates and end-of-step
// transactions enter on the in_ channel; each end of step yields exactly one
// out_ transaction (signal, spread, halt and running totals), other actions
// yield none and action code 3 is dropped. a front register classifies the
// transaction and hands it through a short queue to the execute unit, so the
// input keeps accepting until the queue fills while the execute unit is busy
// or the output stalls. the execute unit applies a price update as it pops
// it, a fill as a split multiply, then an accumulate, and an end of step
// through the 15-step restoring divider that forms the spread in basis
// points; an end of step without a crossed book skips the divider. a
// transaction passes the front register and queue before it executes.
// configuration is a plain write port: index 0 position_limit, index 1
// threshold_bps; write only while the block is idle.
module arbitrage_spread_detector #(
  parameter int QUEUE_DEPTH = asd_pkg::QUEUE_DEPTH  // power of two, at least 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  asd_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output asd_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [asd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [asd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // configuration registers
  logic [asd_pkg::LIMIT_W-1:0]  limit_r;
  logic [asd_pkg::THRESH_W-1:0] thresh_r;

  // front to queue
  logic              fr_push_valid;
  logic              fr_push_ready;
  asd_pkg::cmd_t     fr_push_cmd;

  // queue to execute unit
  logic              q_pop_valid;
  logic              q_pop;
  asd_pkg::cmd_t     q_pop_cmd;

  // execute unit to divider
  asd_pkg::div_req_t div_req;
  asd_pkg::div_rsp_t div_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= asd_pkg::POSITION_LIMIT_RST;
      thresh_r <= asd_pkg::THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        asd_pkg::CFG_POSITION_LIMIT: limit_r  <= asd_pkg::LIMIT_W'(cfg_wdata);
        asd_pkg::CFG_THRESHOLD_BPS:  thresh_r <= cfg_wdata[asd_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // accept and classify
  asd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (fr_push_valid),
    .push_ready (fr_push_ready),
    .push_cmd   (fr_push_cmd)
  );

  // decoupling queue
  asd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_push_valid),
    .push_ready (fr_push_ready),
    .push_cmd   (fr_push_cmd),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop),
    .pop_cmd    (q_pop_cmd)
  );

  // execute unit: accumulators, quotes, end-of-step report
  asd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (q_pop_valid),
    .cmd            (q_pop_cmd),
    .cmd_pop        (q_pop),
    .position_limit (limit_r),
    .threshold_bps  (thresh_r),
    .div_req        (div_req),
    .div_rsp        (div_rsp),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

  // spread * 10000 / mid
  asd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule

@@ tb/sv/spread_checker.sv @@
`timescale 1ns / 1ps
module spread_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  asd_pkg::in_item_t               in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  asd_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [asd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [asd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                              mismatches,
  output int                              reports_owed
);

  // shadow configuration
  logic [asd_pkg::LIMIT_W-1:0]  limit_q;
  logic [asd_pkg::THRESH_W-1:0] thresh_q;

  // shadow book and accumulators
  logic [asd_pkg::ACC_W-1:0]   net_pos;
  logic [asd_pkg::ACC_W-1:0]   pnl;
  logic [asd_pkg::COUNT_W-1:0] fill_cnt;
  logic [asd_pkg::COUNT_W-1:0] sig_cnt;
  logic [asd_pkg::QUOTE_W-1:0] bid_q;
  logic [asd_pkg::QUOTE_W-1:0] ask_q;
  logic                        msg_seen;

  asd_pkg::out_item_t step_reports[$];
  asd_pkg::out_item_t oldest;

  task automatic apply_message(input asd_pkg::in_item_t it);
    logic [asd_pkg::ACC_W-1:0] price_x;
    logic [asd_pkg::ACC_W-1:0] qty_x;
    logic [asd_pkg::ACC_W-1:0] spread;
    logic [asd_pkg::ACC_W-1:0] mid;
    logic [asd_pkg::ACC_W-1:0] bps;
    logic [asd_pkg::ACC_W-1:0] mag;
    logic                      sig;
    logic                      halt;
    asd_pkg::out_item_t        rpt;
    case (it.action)
      asd_pkg::ACT_FILL: begin
        price_x  = {{(asd_pkg::ACC_W-asd_pkg::PRICE_W){it.fill_price[asd_pkg::PRICE_W-1]}},
                    it.fill_price};
        qty_x    = {{(asd_pkg::ACC_W-asd_pkg::QTY_W){1'b0}}, it.fill_size};
        net_pos  = net_pos + qty_x;
        fill_cnt = fill_cnt + asd_pkg::COUNT_W'(1);
        pnl      = pnl - price_x * qty_x;
        msg_seen = 1'b1;
      end
      asd_pkg::ACT_QUOTE: begin
        // only strictly positive quotes replace the kept ones
        if (!it.quote_bid[asd_pkg::PRICE_W-1] && it.quote_bid != '0)
          bid_q = it.quote_bid[asd_pkg::QUOTE_W-1:0];
        if (!it.quote_ask[asd_pkg::PRICE_W-1] && it.quote_ask != '0)
          ask_q = it.quote_ask[asd_pkg::QUOTE_W-1:0];
        msg_seen = 1'b1;
      end
      asd_pkg::ACT_EOS: begin
        sig = 1'b0;
        bps = '0;
        if (bid_q != '0 && ask_q != '0 && bid_q > ask_q) begin
          spread = asd_pkg::ACC_W'(bid_q);
          mid    = asd_pkg::ACC_W'(ask_q);
          mid    = (spread + mid) >> 1;
          spread = spread - asd_pkg::ACC_W'(ask_q);
          if (mid != '0) bps = (spread * asd_pkg::ACC_W'(asd_pkg::BPS_SCALE)) / mid;
          if (bps >= asd_pkg::ACC_W'(thresh_q)) begin
            sig     = 1'b1;
            sig_cnt = sig_cnt + asd_pkg::COUNT_W'(1);
          end
        end
        // magnitude as unsigned, most negative counts as 2^63
        mag      = net_pos[asd_pkg::ACC_W-1] ? -net_pos : net_pos;
        halt     = (mag > asd_pkg::ACC_W'(limit_q)) || (!msg_seen && !sig);
        msg_seen = 1'b0;
        rpt              = '0;
        rpt.signal_valid = sig;
        rpt.spread_bps   = sig ? bps[asd_pkg::BPS_W-1:0] : '0;
        rpt.signal_step  = sig ? it.step_number : '0;
        rpt.halt_request = halt;
        rpt.position_out = net_pos;
        rpt.pnl_out      = pnl;
        rpt.fills_out    = fill_cnt;
        rpt.signals_out  = sig_cnt;
        step_reports.insert(step_reports.size(), rpt);
      end
      default: begin
        // unused action code, dropped
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      limit_q    = asd_pkg::POSITION_LIMIT_RST;
      thresh_q   = asd_pkg::THRESHOLD_RST;
      net_pos    = '0;
      pnl        = '0;
      fill_cnt   = '0;
      sig_cnt    = '0;
      bid_q      = '0;
      ask_q      = '0;
      msg_seen   = 1'b0;
      mismatches = 0;
      step_reports.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (step_reports.size() == 0) begin
          $display("%0t: unexpected report, expected none, actual %p", $time, out_data);
          mismatches++;
        end else begin
          oldest = step_reports.pop_front();
          check_field("signal_valid", 64'(oldest.signal_valid), 64'(out_data.signal_valid));
          check_field("spread_bps", 64'(oldest.spread_bps), 64'(out_data.spread_bps));
          check_field("signal_step", 64'(oldest.signal_step), 64'(out_data.signal_step));
          check_field("halt_request", 64'(oldest.halt_request), 64'(out_data.halt_request));
          check_field("position_out", oldest.position_out, out_data.position_out);
          check_field("pnl_out", oldest.pnl_out, out_data.pnl_out);
          check_field("fills_out", 64'(oldest.fills_out), 64'(out_data.fills_out));
          check_field("signals_out", 64'(oldest.signals_out), 64'(out_data.signals_out));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          asd_pkg::CFG_POSITION_LIMIT: limit_q  = cfg_wdata[asd_pkg::LIMIT_W-1:0];
          asd_pkg::CFG_THRESHOLD_BPS:  thresh_q = cfg_wdata[asd_pkg::THRESH_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) apply_message(in_data);
    end
    reports_owed = step_reports.size();
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
module tb;

  // action code the block must drop
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [asd_pkg::LIMIT_W-1:0]  LIMIT_MAX  = '1;
  localparam logic [asd_pkg::THRESH_W-1:0] THRESH_MAX = '1;
  localparam logic [asd_pkg::PRICE_W-1:0]  PRICE_MAX  = {1'b0, {(asd_pkg::PRICE_W-1){1'b1}}};
  localparam logic [asd_pkg::PRICE_W-1:0]  PRICE_MIN  = {1'b1, {(asd_pkg::PRICE_W-1){1'b0}}};
  localparam logic [asd_pkg::PRICE_W-1:0]  PRICE_NEG1 = '1;

  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 125;
  // covers an end of step in the divider plus the front register and queue
  localparam int DRAIN_CYCLES  = 64;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  asd_pkg::in_item_t               in_data;
  logic                            out_valid;
  logic                            out_ready;
  asd_pkg::out_item_t              out_data;
  logic                            cfg_we;
  logic [asd_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [asd_pkg::CFG_DATA_W-1:0]  cfg_wdata;

  int mismatches;
  int reports_owed;

  // when set, neither side inserts gaps
  bit no_gaps;
  // threshold currently programmed, steers quote generation toward it
  int thresh_now;

  arbitrage_spread_detector u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  spread_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .reports_owed (reports_owed)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [asd_pkg::PRICE_W-1:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[asd_pkg::PRICE_W-1:0];
  endfunction

  // every field random, callers overwrite what matters
  function automatic asd_pkg::in_item_t noise_item();
    asd_pkg::in_item_t it;
    it.action      = 2'($urandom);
    it.fill_price  = rand48();
    it.fill_size   = $urandom;
    it.quote_bid   = rand48();
    it.quote_ask   = rand48();
    it.step_number = $urandom;
    return it;
  endfunction

  function automatic asd_pkg::in_item_t fill_item(input logic [asd_pkg::PRICE_W-1:0] price,
                                                  input logic [asd_pkg::QTY_W-1:0] qty);
    asd_pkg::in_item_t it;
    it            = noise_item();
    it.action     = asd_pkg::ACT_FILL;
    it.fill_price = price;
    it.fill_size  = qty;
    return it;
  endfunction

  function automatic asd_pkg::in_item_t quote_item(input logic [asd_pkg::PRICE_W-1:0] bid,
                                                   input logic [asd_pkg::PRICE_W-1:0] ask);
    asd_pkg::in_item_t it;
    it           = noise_item();
    it.action    = asd_pkg::ACT_QUOTE;
    it.quote_bid = bid;
    it.quote_ask = ask;
    return it;
  endfunction

  function automatic asd_pkg::in_item_t eos_item(input logic [asd_pkg::STEP_W-1:0] step);
    asd_pkg::in_item_t it;
    it             = noise_item();
    it.action      = asd_pkg::ACT_EOS;
    it.step_number = step;
    return it;
  endfunction

  // zero or negative, so the block keeps the old quote
  function automatic logic [asd_pkg::PRICE_W-1:0] dead_quote();
    logic [asd_pkg::PRICE_W-1:0] q;
    q = rand48();
    q[asd_pkg::PRICE_W-1] = 1'b1;
    return ($urandom_range(0, 1) == 0) ? '0 : q;
  endfunction

  // quote pair whose spread often sits near the threshold
  function automatic asd_pkg::in_item_t spread_quote();
    logic [63:0] m;
    logic [63:0] b;
    int          tgt;
    int          pick;
    if ($urandom_range(0, 7) == 0) m = 64'($urandom_range(1, 200));
    else m = ({$urandom, $urandom} & 64'h1FFF_FFFF_FFFF) + 64'd1;
    if ($urandom_range(0, 4) == 0) tgt = int'($urandom_range(0, 19999));
    else begin
      tgt = thresh_now + int'($urandom_range(0, 6)) - 3;
      if (tgt < 0) tgt = 0;
      if (tgt > 19999) tgt = int'($urandom_range(0, 19999));
    end
    b    = m + (m / 64'd10000) * 64'(tgt) + 64'($urandom_range(0, 3));
    pick = int'($urandom_range(0, 9));
    case (pick)
      0, 1, 2, 3, 4, 5: return quote_item({1'b0, b[46:0]}, {1'b0, m[46:0]});
      6:                return quote_item({1'b0, m[46:0]}, {1'b0, b[46:0]});
      7:                return quote_item({1'b0, b[46:0]}, dead_quote());
      8:                return quote_item(dead_quote(), {1'b0, m[46:0]});
      default:          return quote_item(rand48(), rand48());
    endcase
  endfunction

  function automatic asd_pkg::in_item_t random_fill();
    logic [31:0]                 r;
    logic [asd_pkg::PRICE_W-1:0] price;
    logic [asd_pkg::QTY_W-1:0]   qty;
    r = $urandom;
    if ($urandom_range(0, 1) == 0) price = rand48();
    else price = {{(asd_pkg::PRICE_W-32){r[31]}}, r};
    if ($urandom_range(0, 7) == 0) qty = $urandom;
    else qty = $urandom_range(0, 1000);
    return fill_item(price, qty);
  endfunction

  // one input transaction with a random lead-in gap unless no_gaps is set
  task automatic push_message(input asd_pkg::in_item_t it);
    int gap;
    gap = no_gaps ? 0 : int'($urandom_range(0, 15));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // wait for every report, let trailing fills and quotes drain, then reprogram
  task automatic settle_and_program(input logic [asd_pkg::LIMIT_W-1:0] lim,
                                    input logic [asd_pkg::THRESH_W-1:0] thr);
    logic [63:0] w;
    in_valid <= 1'b0;
    while (reports_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= asd_pkg::CFG_POSITION_LIMIT;
    cfg_wdata <= lim;
    @(negedge clk);
    // upper data bits are don't care for the threshold, keep them busy
    w = {$urandom, $urandom};
    w[asd_pkg::THRESH_W-1:0] = thr;
    cfg_index <= asd_pkg::CFG_THRESHOLD_BPS;
    cfg_wdata <= w[asd_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we     <= 1'b0;
    thresh_now = int'(thr);
  endtask

  // mostly well formed traffic, some dropped action codes on top
  task automatic random_burst(input int count);
    int                done_cnt;
    int                r;
    asd_pkg::in_item_t it;
    done_cnt = 0;
    while (done_cnt < count) begin
      r = int'($urandom_range(0, 99));
      if (r < 30) it = random_fill();
      else if (r < 65) it = spread_quote();
      else if (r < 95) it = eos_item($urandom);
      else begin
        it        = noise_item();
        it.action = ACT_UNUSED;
      end
      push_message(it);
      if (it.action != ACT_UNUSED) done_cnt++;
    end
  endtask

  // result side: random stall before each transaction unless no_gaps is set
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = no_gaps ? 0 : int'($urandom_range(0, 15));
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    asd_pkg::in_item_t            it;
    logic [asd_pkg::LIMIT_W-1:0]  lim;
    logic [asd_pkg::THRESH_W-1:0] thr;
    logic [63:0]                  r;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = asd_pkg::CFG_POSITION_LIMIT;
    cfg_wdata  = '0;
    no_gaps    = 1'b0;
    thresh_now = int'(asd_pkg::THRESHOLD_RST);
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // reset configuration: limit 1000000, threshold 5
    push_message(eos_item('0));                          // idle step, no quotes
    push_message(quote_item(PRICE_NEG1, '0));            // both ignored
    push_message(eos_item('1));                          // still no quotes
    push_message(quote_item(PRICE_MAX, 48'd1));          // widest crossed book
    push_message(eos_item('1));
    push_message(quote_item(PRICE_MIN, 48'd1000000));    // bid ignored, ask kept
    push_message(quote_item(48'd1000000, 48'd1000000));  // bid equal to ask
    push_message(eos_item($urandom));
    push_message(quote_item(48'd999000, '0));            // bid below ask
    push_message(eos_item($urandom));
    push_message(eos_item($urandom));                    // idle after a step
    push_message(fill_item(PRICE_MAX, '1));
    push_message(fill_item(PRICE_MIN, '1));
    push_message(fill_item(PRICE_NEG1, '0));
    it        = noise_item();
    it.action = ACT_UNUSED;
    push_message(it);                                    // dropped code
    push_message(eos_item($urandom));                    // over the position limit
    push_message(quote_item(48'd1000500, 48'd1000000));  // 4 bps, just under
    push_message(eos_item($urandom));
    push_message(quote_item(48'd1000501, 48'd1000000));  // 5 bps, at threshold
    push_message(eos_item($urandom));

    for (int ph = 1; ph <= RANDOM_PHASES; ph++) begin
      case (ph)
        1: begin lim = LIMIT_MAX; thr = '0; end
        2: begin lim = '0; thr = THRESH_MAX; end
        3: begin lim = asd_pkg::POSITION_LIMIT_RST; thr = asd_pkg::THRESHOLD_RST; end
        default: begin
          r   = {$urandom, $urandom};
          lim = ($urandom_range(0, 3) == 0) ? r[asd_pkg::LIMIT_W-1:0]
                                            : asd_pkg::LIMIT_W'(r[35:0]);
          thr = asd_pkg::THRESH_W'($urandom_range(0, 40));
        end
      endcase
      no_gaps = (ph == 3) || ($urandom_range(0, 3) == 0);
      settle_and_program(lim, thr);
      if (ph == 1) begin
        // one tick apart at 2^46: zero bps still signals at threshold zero
        push_message(quote_item(48'h4000_0000_0001, 48'h4000_0000_0000));
        push_message(eos_item($urandom));
      end else if (ph == 2) begin
        // widest spread stays below the top threshold
        push_message(quote_item(PRICE_MAX, 48'd1));
        push_message(eos_item($urandom));
      end
      random_burst(PHASE_ITEMS);
    end

    in_valid <= 1'b0;
    while (reports_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    // reports still owed at this point also count against the run
    if (mismatches == 0 && reports_owed == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
